// ===== rtl/core/lcd_pkg.sv =====
// Package for the lidar cluster detector: register indexes, widths, result kinds,
// the arctangent table and the fixed CORDIC constants. No dependencies.
package lcd_pkg;
	localparam int ScanPointsDefault = 1024;
	localparam int CordicSteps = 20;
	localparam logic [10:0] Sat11 = 11'd2047;
	localparam logic [33:0] CordicGain = 34'd652032874;

	localparam logic [2:0] REG_MAX_CONSIDER = 3'd0;
	localparam logic [2:0] REG_RANGE_FLOOR = 3'd1;
	localparam logic [2:0] REG_RANGE_CEILING = 3'd2;
	localparam logic [2:0] REG_START_ANGLE = 3'd3;
	localparam logic [2:0] REG_ANGLE_STEP = 3'd4;
	localparam logic [2:0] REG_MIN_CLUSTER = 3'd5;
	localparam logic [2:0] REG_MAX_CLUSTER = 3'd6;

	localparam logic KIND_DETECT = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// One closed cluster or one summary, as handed from front to back.
	// The index is kept at full sample width so that the angle sees all of it.
	typedef struct packed {
		logic        kind;
		logic [15:0] near_range;
		logic [15:0] near_index;
		logic [10:0] found_count;
		logic        last;
	} job_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10679838;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage

// ===== rtl/core/lidar_cluster_detector.sv =====
// Top level of the lidar cluster detector: configuration registers, front,
// job queue and back part. Depends on lcd_pkg, lcd_front, lcd_fifo, lcd_back.
//
// The block takes one range sample per cycle while its four-entry job queue
// has at least two free entries; cluster tracking in the front keeps pace with
// the sensor. Each detection takes the back part through fetching the job, one
// multiply, 20 CORDIC iterations on the shared rotator and one output step,
// and a summary through fetch and output only, so the sustained rate is
// one sample per cycle while detections are sparse and is bounded by the
// CORDIC loop when they come close together. A scan end that also closes an
// accepted cluster stalls the input while the summary job follows the
// detection into the queue. Results wait in an output register, so a stalled
// consumer only holds the back part.
module lidar_cluster_detector #(
	parameter int ScanPoints = lcd_pkg::ScanPointsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] range_mm,
	input  logic        scan_end,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [9:0]  near_index,
	output logic [15:0] near_range,
	output logic [10:0] found_count,
	output logic        last
);
	import lcd_pkg::*;

	logic [15:0] max_consider_q, range_floor_q, range_ceiling_q, start_angle_q, angle_step_q;
	logic [10:0] min_cluster_q, max_cluster_q;

	// Configuration writes land directly; unlisted indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_consider_q <= 16'd1000;
			range_floor_q <= 16'd0;
			range_ceiling_q <= 16'd65535;
			start_angle_q <= 16'd0;
			angle_step_q <= 16'd64;
			min_cluster_q <= 11'd3;
			max_cluster_q <= 11'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_CONSIDER: max_consider_q <= cfg_data;
				REG_RANGE_FLOOR: range_floor_q <= cfg_data;
				REG_RANGE_CEILING: range_ceiling_q <= cfg_data;
				REG_START_ANGLE: start_angle_q <= cfg_data;
				REG_ANGLE_STEP: angle_step_q <= cfg_data;
				REG_MIN_CLUSTER: min_cluster_q <= cfg_data[10:0];
				REG_MAX_CLUSTER: max_cluster_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	logic  front_idle, push_valid, free2, job_valid, job_take, in_take, push_wr;
	job_t  push_job, job;

	// A sample needs room for up to two jobs and no leftover summary pending.
	assign in_stall = !(front_idle && free2);
	assign in_take = in_valid && !in_stall;
	assign push_wr = push_valid && (front_idle ? 1'b1 : free2);

	lcd_front #(.ScanPoints(ScanPoints)) u_front (
		.clk, .arst_n, .in_take, .range_mm, .scan_end,
		.max_consider(max_consider_q), .range_floor(range_floor_q),
		.range_ceiling(range_ceiling_q), .min_cluster(min_cluster_q),
		.max_cluster(max_cluster_q), .idle(front_idle),
		.push_valid, .push_job, .push_ready(push_wr)
	);

	lcd_fifo u_fifo (
		.clk, .arst_n, .wr_en(push_wr), .wr_job(push_job), .free2,
		.rd_valid(job_valid), .rd_job(job), .rd_en(job_take)
	);

	lcd_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_take,
		.start_angle(start_angle_q), .angle_step(angle_step_q),
		.out_valid, .out_stall, .kind, .pos_x, .pos_y, .near_index,
		.near_range, .found_count, .last
	);
endmodule

// ===== rtl/core/lcd_front.sv =====
// Front part: qualifies range samples, tracks clusters and the scan count,
// and pushes detection and summary jobs. Depends on lcd_pkg.
module lcd_front #(
	parameter int ScanPoints = lcd_pkg::ScanPointsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_take,
	input  logic [15:0]        range_mm,
	input  logic               scan_end,
	input  logic [15:0]        max_consider,
	input  logic [15:0]        range_floor,
	input  logic [15:0]        range_ceiling,
	input  logic [10:0]        min_cluster,
	input  logic [10:0]        max_cluster,
	output logic               idle,
	output logic               push_valid,
	output lcd_pkg::job_t      push_job,
	input  logic               push_ready
);
	import lcd_pkg::*;
	localparam int IdxW = $clog2(ScanPoints);

	logic              in_cluster_q;
	logic [10:0]       size_q;
	logic [15:0]       near_r_q;
	logic [IdxW-1:0]   near_i_q;
	logic [IdxW-1:0]   sample_q;
	logic [10:0]       count_q;
	// A second job (the summary after a cluster accepted at scan end) waits here.
	logic              pend_q;
	job_t              pend_job_q;

	logic        qual, close_now;
	logic [10:0] cnt_inc;
	job_t        det_job, sum_job;

	assign qual = (range_mm > range_floor) && (range_mm < max_consider);
	assign close_now = in_cluster_q && (!qual || scan_end);
	assign cnt_inc = (count_q < Sat11) ? count_q + 11'd1 : count_q;
	assign idle = !pend_q;

	// Near sample values that would result if this sample joins the cluster.
	logic [15:0]     nr_n;
	logic [IdxW-1:0] ni_n;
	logic [10:0]     sz_n;
	always_comb begin
		nr_n = in_cluster_q ? near_r_q : range_ceiling;
		ni_n = in_cluster_q ? near_i_q : sample_q;
		sz_n = in_cluster_q ? size_q : 11'd0;
		if (range_mm < nr_n) begin
			nr_n = range_mm;
			ni_n = sample_q;
		end
		if (sz_n < Sat11) sz_n = sz_n + 11'd1;
	end

	// Cluster closing at scan end uses the updated cluster when it qualifies.
	logic [15:0]     cr;
	logic [IdxW-1:0] ci;
	logic [10:0]     cs;
	logic            cl_any, cl_ok;
	logic [10:0]     cl_cnt;
	always_comb begin
		if (qual) begin
			cr = nr_n; ci = ni_n; cs = sz_n;
		end else begin
			cr = near_r_q; ci = near_i_q; cs = size_q;
		end
		cl_any = qual ? scan_end : close_now;
		cl_ok = cl_any && (cs >= min_cluster) && (cs <= max_cluster);
		cl_cnt = cl_ok ? cnt_inc : count_q;
		det_job.kind = KIND_DETECT;
		det_job.near_range = cr;
		det_job.near_index = 16'(ci);
		det_job.found_count = cnt_inc;
		det_job.last = !scan_end;
		sum_job.kind = KIND_SUMMARY;
		sum_job.near_range = 16'd0;
		sum_job.near_index = 16'd0;
		sum_job.found_count = cl_cnt;
		sum_job.last = 1'b1;
	end

	always_comb begin
		push_valid = 1'b0;
		push_job = det_job;
		if (pend_q) begin
			push_valid = 1'b1;
			push_job = pend_job_q;
		end else if (in_take) begin
			if (cl_ok) begin
				push_valid = 1'b1;
			end else if (scan_end) begin
				push_valid = 1'b1;
				push_job = sum_job;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cluster_q <= 1'b0;
			size_q <= '0;
			near_r_q <= '0;
			near_i_q <= '0;
			sample_q <= '0;
			count_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (pend_q && push_ready) pend_q <= 1'b0;
			if (in_take) begin
				if (cl_ok && scan_end) begin
					pend_q <= 1'b1;
					pend_job_q <= sum_job;
				end
				if (qual) begin
					in_cluster_q <= 1'b1;
					size_q <= sz_n;
					near_r_q <= nr_n;
					near_i_q <= ni_n;
				end else begin
					in_cluster_q <= 1'b0;
				end
				if (scan_end) begin
					in_cluster_q <= 1'b0;
					sample_q <= '0;
					count_q <= '0;
				end else begin
					sample_q <= (sample_q == IdxW'(ScanPoints - 1)) ? '0 : sample_q + 1'b1;
					count_q <= cl_cnt;
				end
			end
		end
	end
endmodule

// ===== rtl/core/lcd_fifo.sv =====
// Short job queue between the front and the back part, four entries deep.
// Depends on lcd_pkg for the job type.
module lcd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lcd_pkg::job_t wr_job,
	output logic          free2,
	output logic          rd_valid,
	output lcd_pkg::job_t rd_job,
	input  logic          rd_en
);
	import lcd_pkg::*;
	job_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign free2 = cnt_q <= 3'd2;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr_en) - 3'(rd_en);
		end
	end
endmodule

// ===== rtl/core/lcd_back.sv =====
// Back part: turns a job into a result, running an iterative CORDIC for
// detections, with an output register. Depends on lcd_pkg.
module lcd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  lcd_pkg::job_t job,
	output logic          job_take,
	input  logic [15:0]   start_angle,
	input  logic [15:0]   angle_step,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          kind,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [9:0]    near_index,
	output logic [15:0]   near_range,
	output logic [10:0]   found_count,
	output logic          last
);
	import lcd_pkg::*;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_ITER = 3'd2;
	localparam logic [2:0] ST_DONE = 3'd3;

	logic [2:0]  st_q;
	logic [4:0]  it_q;
	job_t        job_q;
	logic        flip_q;
	logic signed [37:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [15:0] ang_q;

	logic out_free;
	assign out_free = !out_valid || !out_stall;
	assign job_take = (st_q == ST_IDLE) && job_valid;

	logic signed [37:0] dx, dy, rx, ry;
	logic signed [53:0] prod;
	logic [31:0] a32;
	always_comb begin
		dx = y_q >>> it_q;
		dy = x_q >>> it_q;
		prod = $signed({4'd0, job_q.near_range, 34'd0} >> 34) * $signed({20'd0, CordicGain});
		a32 = {ang_q, 16'd0};
		if (a32[31] ^ a32[30]) a32 = a32 + 32'h8000_0000;
		rx = x_q + 38'sd32768;
		ry = y_q + 38'sd32768;
	end

	function automatic logic signed [16:0] to_mm(input logic signed [37:0] v, input logic f);
		logic signed [21:0] m;
		m = 22'(v >>> 16);
		if (f) m = -m;
		if (m > 22'sd65535) m = 22'sd65535;
		if (m < -22'sd65535) m = -22'sd65535;
		return 17'(m);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			it_q <= '0;
		end else begin
			// A new result replaces the one taken in the same cycle.
			if (st_q == ST_DONE && out_free) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid) begin
					job_q <= job;
					ang_q <= start_angle + 16'(job.near_index * angle_step);
					st_q <= (job.kind == KIND_DETECT) ? ST_MUL : ST_DONE;
				end
				ST_MUL: begin
					x_q <= 38'(prod >>> 14);
					y_q <= '0;
					z_q <= 34'($signed(a32));
					flip_q <= ang_q[15] ^ ang_q[14];
					it_q <= '0;
					st_q <= ST_ITER;
				end
				ST_ITER: begin
					if (!z_q[33]) begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						z_q <= z_q - $signed({2'd0, atan_entry(it_q)});
					end else begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						z_q <= z_q + $signed({2'd0, atan_entry(it_q)});
					end
					it_q <= it_q + 5'd1;
					if (it_q == 5'(CordicSteps - 1)) st_q <= ST_DONE;
				end
				ST_DONE: if (out_free) begin
					kind <= job_q.kind;
					found_count <= job_q.found_count;
					last <= job_q.last;
					if (job_q.kind == KIND_DETECT) begin
						pos_x <= to_mm(rx, flip_q);
						pos_y <= to_mm(ry, flip_q);
						near_index <= job_q.near_index[9:0];
						near_range <= job_q.near_range;
					end else begin
						pos_x <= '0;
						pos_y <= '0;
						near_index <= '0;
						near_range <= '0;
					end
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
